>>> sv/tkfc_pkg.sv
// Shared types and constants of the time-keyed frame cache.
`timescale 1ns / 1ps
`default_nettype none

package tkfc_pkg;

   localparam int ACTION_W = 2;
   localparam int TIME_W   = 31;
   localparam int TOL_W    = 16;
   localparam int FRAME_W  = 32;
   localparam int LIMIT_W  = 5;
   localparam int OCC_W    = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_RESIZE = 2'd3
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // transaction accepted, capture it and arm the scan
      logic scan;    // one scan step
      logic finish;  // update cache state and load the response
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_scan;
      logic scan_hit;
      logic scan_end;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/tkfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tkfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/tkfc_ctrl.sv
// Controller state machine of the frame cache: accept, scan, finish.
`timescale 1ns / 1ps
`default_nettype none

module tkfc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tkfc_pkg::dp_status_type status,
   output tkfc_pkg::ctrl_cmd_type      cmd
);

   import tkfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = status.needs_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit || status.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/tkfc_dp.sv
// Datapath of the frame cache: ring storage, scan compare, state update, response.
`timescale 1ns / 1ps
`default_nettype none

module tkfc_dp #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tkfc_pkg::ctrl_cmd_type            cmd,
   output tkfc_pkg::dp_status_type                status,
   input  wire logic [tkfc_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [tkfc_pkg::TIME_W-1:0]       req_time_ms,
   input  wire logic [tkfc_pkg::TOL_W-1:0]        req_tolerance,
   input  wire logic [tkfc_pkg::FRAME_W-1:0]      req_frame_handle,
   input  wire logic [tkfc_pkg::LIMIT_W-1:0]      req_new_limit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic      [tkfc_pkg::FRAME_W-1:0]      rsp_frame_out,
   output logic      [tkfc_pkg::OCC_W-1:0]        rsp_occupancy
);

   import tkfc_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int EW = TIME_W + FRAME_W;
   localparam logic [CW:0]   CAP_S = (CW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

   // ring index plus offset, offset at most CAPACITY
   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] offs);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(offs);
      if (sum >= CAP_S) begin
         sum = sum - CAP_S;
      end
      return sum[IW-1:0];
   endfunction

   // transaction registers
   action_type           act_ff;
   logic [TIME_W-1:0]    key_ff;
   logic [TOL_W-1:0]     tol_ff;
   logic [FRAME_W-1:0]   handle_ff;
   logic [LIMIT_W-1:0]   lim_ff;

   // cache control state
   logic [IW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] limit_ff, limit_in;

   // scan state
   logic [CW-1:0]      rd_age_ff;
   logic               cmp_vld_ff;
   logic [IW-1:0]      cmp_slot_ff;
   logic               found_ff;
   logic [IW-1:0]      hit_slot_ff;
   logic [FRAME_W-1:0] found_frame_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [OCC_W-1:0]   rsp_occ_ff;

   // memory ports
   logic          rd_issue;
   logic [IW-1:0] rd_slot;
   logic [EW-1:0] rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;

   // compare
   logic [TIME_W-1:0] ent_time;
   logic [TIME_W-1:0] diff;
   logic              match;

   // finish
   logic          st_drop;
   logic [CW-1:0] st_count;
   logic [IW-1:0] st_oldest;
   logic [LW-1:0] lim_ext;
   logic [CW-1:0] new_lim;
   logic [CW-1:0] kept;

   assign rd_issue = cmd.scan && (rd_age_ff < count_ff);
   assign rd_slot  = ring_add(oldest_ff, rd_age_ff);

   tkfc_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({key_ff, handle_ff}),
      .rd_en   (rd_issue),
      .rd_addr (rd_slot),
      .rd_data (rd_data)
   );

   assign ent_time = rd_data[EW-1:FRAME_W];
   assign diff     = (ent_time >= key_ff) ? (ent_time - key_ff) : (key_ff - ent_time);
   assign match    = (act_ff == ACT_STORE) ? (ent_time == key_ff)
                                           : (diff <= TIME_W'(tol_ff));

   always_comb begin
      status.needs_scan = (action_type'(req_action) == ACT_LOOKUP) ||
                          (action_type'(req_action) == ACT_STORE);
      status.scan_hit   = cmp_vld_ff && match;
      status.scan_end   = !cmp_vld_ff && (rd_age_ff >= count_ff);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // state update at finish
   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      wr_en     = 1'b0;
      wr_addr   = hit_slot_ff;
      st_drop   = count_ff >= limit_ff;
      st_count  = st_drop ? (count_ff - CW'(1)) : count_ff;
      st_oldest = st_drop ? ring_add(oldest_ff, CW'(1)) : oldest_ff;
      lim_ext   = LW'(lim_ff);
      new_lim   = (lim_ext > CAP_L) ? CW'(CAP_L) : CW'(lim_ext);
      kept      = (count_ff > new_lim) ? new_lim : count_ff;
      case (act_ff)
         ACT_LOOKUP: begin
         end
         ACT_STORE: begin
            if (found_ff) begin
               // same time already cached: rewrite in place, age unchanged
               wr_en = cmd.finish;
            end else if (limit_ff != '0) begin
               oldest_in = st_oldest;
               if (st_count < CAP_C) begin
                  wr_en    = cmd.finish;
                  wr_addr  = ring_add(st_oldest, st_count);
                  count_in = st_count + CW'(1);
               end else begin
                  count_in = st_count;
               end
            end
         end
         ACT_CLEAR: begin
            count_in  = '0;
            oldest_in = '0;
         end
         ACT_RESIZE: begin
            limit_in  = new_lim;
            count_in  = kept;
            oldest_in = ring_add(oldest_ff, count_ff - kept);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         limit_ff     <= CAP_C;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rd_age_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
            limit_ff  <= limit_in;
         end
         if (cmd.load) begin
            rd_age_ff  <= '0;
            cmp_vld_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else if (cmd.scan) begin
            cmp_vld_ff <= rd_issue;
            if (rd_issue) begin
               rd_age_ff <= rd_age_ff + CW'(1);
            end
            if (cmp_vld_ff && match) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= action_type'(req_action);
         key_ff    <= req_time_ms;
         tol_ff    <= req_tolerance;
         handle_ff <= req_frame_handle;
         lim_ff    <= req_new_limit;
      end
      if (cmd.scan) begin
         cmp_slot_ff <= rd_slot;
         if (cmp_vld_ff && match) begin
            hit_slot_ff    <= cmp_slot_ff;
            found_frame_ff <= rd_data[FRAME_W-1:0];
         end
      end
      if (cmd.finish) begin
         rsp_hit_ff   <= (act_ff == ACT_LOOKUP) && found_ff;
         rsp_frame_ff <= ((act_ff == ACT_LOOKUP) && found_ff) ? found_frame_ff : '0;
         rsp_occ_ff   <= OCC_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

>>> sv/time_keyed_fifo_frame_cache_top.sv
// Top level of the time-keyed frame cache.
// Usage:
//   A cache of frame handles keyed by a millisecond timestamp, oldest first.
//   Request channel (req_*): action lookup, store, clear or resize, with key,
//   tolerance, handle and new limit. Response channel (rsp_*): hit flag,
//   matched handle (0 on miss or non-lookup) and occupancy after the
//   transaction. Exactly one response per request, in order.
//   Lookup and store scan the entries oldest first through a RAM with
//   registered read, one entry per cycle, and end early on a hit. Clear
//   and resize skip the scan. One transaction is in work at a time.
//   The response sits in an output register, so the next request is taken
//   while an earlier response still waits. A stalled receiver holds the
//   response; the block then stops only when a second one is ready.
//   Reset (synchronous): empty cache, oldest pointer 0, limit CAPACITY.
//   Entry storage is not cleared; only occupied slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module time_keyed_fifo_frame_cache_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tkfc_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [tkfc_pkg::TIME_W-1:0]       req_time_ms,
   input  wire logic [tkfc_pkg::TOL_W-1:0]        req_tolerance,
   input  wire logic [tkfc_pkg::FRAME_W-1:0]      req_frame_handle,
   input  wire logic [tkfc_pkg::LIMIT_W-1:0]      req_new_limit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic      [tkfc_pkg::FRAME_W-1:0]      rsp_frame_out,
   output logic      [tkfc_pkg::OCC_W-1:0]        rsp_occupancy
);

   import tkfc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tkfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkfc_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_time_ms      (req_time_ms),
      .req_tolerance    (req_tolerance),
      .req_frame_handle (req_frame_handle),
      .req_new_limit    (req_new_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

`default_nettype wire

>>> sv/tkfc_checker.sv
// Port-level assertions of the frame cache and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tkfc_checker #(
   parameter int CAPACITY = 16
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_hit,
   input wire logic [tkfc_pkg::FRAME_W-1:0]   rsp_frame_out,
   input wire logic [tkfc_pkg::OCC_W-1:0]     rsp_occupancy
);

   import tkfc_pkg::*;

   localparam logic [OCC_W:0] CAP_O = (OCC_W + 1)'(CAPACITY);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_frame_out) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_frame_out == '0)
      else $error("frame handle non-zero without a hit");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_occupancy} <= CAP_O || CAPACITY > 31)
      else $error("occupancy above capacity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind time_keyed_fifo_frame_cache_top tkfc_checker #(
   .CAPACITY (CAPACITY)
) u_tkfc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_hit       (rsp_hit),
   .rsp_frame_out (rsp_frame_out),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire

>>> tb/tkfc_checker.sv
// Checker for the time-keyed frame cache: predicts each response and compares it with the one seen.
`timescale 1ns / 1ps

module tkfc_scoreboard #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [tkfc_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [tkfc_pkg::TIME_W-1:0]       req_time_ms,
   input  wire logic [tkfc_pkg::TOL_W-1:0]        req_tolerance,
   input  wire logic [tkfc_pkg::FRAME_W-1:0]      req_frame_handle,
   input  wire logic [tkfc_pkg::LIMIT_W-1:0]      req_new_limit,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic                              rsp_hit,
   input  wire logic [tkfc_pkg::FRAME_W-1:0]      rsp_frame_out,
   input  wire logic [tkfc_pkg::OCC_W-1:0]        rsp_occupancy,
   output int                                     mismatches,
   output int                                     outstanding,
   output int                                     lookup_hits
);

   typedef struct {
      logic                          hit;
      logic [tkfc_pkg::FRAME_W-1:0]  frame;
      logic [tkfc_pkg::OCC_W-1:0]    occ;
   } cache_rsp_type;

   // shadow of the cache contents, oldest first from head
   logic [tkfc_pkg::TIME_W-1:0]  shadow_time  [CAPACITY];
   logic [tkfc_pkg::FRAME_W-1:0] shadow_frame [CAPACITY];
   int unsigned                  head;
   int unsigned                  count;
   int unsigned                  limit;

   cache_rsp_type expected_rsp_q [$];
   int            fails = 0;
   int            hits = 0;

   task automatic cache_predict(input tkfc_pkg::action_type act,
                                input logic [tkfc_pkg::TIME_W-1:0] key,
                                input logic [tkfc_pkg::TOL_W-1:0] tol,
                                input logic [tkfc_pkg::FRAME_W-1:0] handle,
                                input logic [tkfc_pkg::LIMIT_W-1:0] lim,
                                output cache_rsp_type r);
      int unsigned s;
      logic [31:0] t;
      logic [31:0] k;
      logic [31:0] diff;
      bit          replaced;
      r.hit   = 1'b0;
      r.frame = '0;
      k       = {1'b0, key};
      case (act)
         tkfc_pkg::ACT_LOOKUP: begin
            for (int age = 0; age < count && !r.hit; age++) begin
               s    = (head + age) % CAPACITY;
               t    = {1'b0, shadow_time[s]};
               diff = (t >= k) ? t - k : k - t;
               if ((tol == 0) ? (t == k) : (diff <= {16'd0, tol})) begin
                  r.hit   = 1'b1;
                  r.frame = shadow_frame[s];
               end
            end
         end
         tkfc_pkg::ACT_STORE: begin
            replaced = 1'b0;
            for (int age = 0; age < count && !replaced; age++) begin
               s = (head + age) % CAPACITY;
               if (shadow_time[s] == key) begin
                  shadow_frame[s] = handle;   // age of the entry is kept
                  replaced        = 1'b1;
               end
            end
            if (!replaced && limit > 0) begin
               if (count >= limit) begin
                  head  = (head + 1) % CAPACITY;
                  count = count - 1;
               end
               if (count < CAPACITY) begin
                  s               = (head + count) % CAPACITY;
                  shadow_time[s]  = key;
                  shadow_frame[s] = handle;
                  count           = count + 1;
               end
            end
         end
         tkfc_pkg::ACT_CLEAR: begin
            count = 0;
            head  = 0;
         end
         default: begin
            limit = (lim > CAPACITY) ? CAPACITY : lim;
            while (count > limit) begin
               head  = (head + 1) % CAPACITY;
               count = count - 1;
            end
         end
      endcase
      r.occ = count[tkfc_pkg::OCC_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      cache_rsp_type want;
      if (reset) begin
         head  = 0;
         count = 0;
         limit = CAPACITY;
         expected_rsp_q.delete();
      end else begin
         // a request accepted at this edge cannot be answered at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding: hit %0d frame %h occ %0d",
                      rsp_hit, rsp_frame_out, rsp_occupancy);
               fails++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  fails++;
               end
               if (rsp_frame_out !== want.frame) begin
                  $error("frame_out: expected %h, got %h", want.frame, rsp_frame_out);
                  fails++;
               end
               if (rsp_occupancy !== want.occ) begin
                  $error("occupancy: expected %0d, got %0d", want.occ, rsp_occupancy);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            cache_predict(tkfc_pkg::action_type'(req_action), req_time_ms, req_tolerance,
                          req_frame_handle, req_new_limit, want);
            if (want.hit)
               hits++;
            expected_rsp_q.insert(expected_rsp_q.size(), want);
         end
      end
      mismatches  <= fails;
      outstanding <= expected_rsp_q.size();
      lookup_hits <= hits;
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for the time-keyed frame cache: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_RANDOM    = 550;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [tkfc_pkg::ACTION_W-1:0]     req_action;
   logic [tkfc_pkg::TIME_W-1:0]       req_time_ms;
   logic [tkfc_pkg::TOL_W-1:0]        req_tolerance;
   logic [tkfc_pkg::FRAME_W-1:0]      req_frame_handle;
   logic [tkfc_pkg::LIMIT_W-1:0]      req_new_limit;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_hit;
   logic [tkfc_pkg::FRAME_W-1:0]      rsp_frame_out;
   logic [tkfc_pkg::OCC_W-1:0]        rsp_occupancy;

   int mismatches;
   int outstanding;
   int lookup_hits;
   int cycles = 0;
   int sent = 0;
   int act_count [4] = '{0, 0, 0, 0};
   bit steady = 1'b0;

   time_keyed_fifo_frame_cache_top #(.CAPACITY(CAPACITY)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_time_ms      (req_time_ms),
      .req_tolerance    (req_tolerance),
      .req_frame_handle (req_frame_handle),
      .req_new_limit    (req_new_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_occupancy    (rsp_occupancy)
   );

   tkfc_scoreboard #(.CAPACITY(CAPACITY)) u_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_time_ms      (req_time_ms),
      .req_tolerance    (req_tolerance),
      .req_frame_handle (req_frame_handle),
      .req_new_limit    (req_new_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_occupancy    (rsp_occupancy),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .lookup_hits      (lookup_hits)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // one request transaction, with an occasional gap in front of it
   task automatic send_req(input tkfc_pkg::action_type act,
                           input logic [tkfc_pkg::TIME_W-1:0] key,
                           input logic [tkfc_pkg::TOL_W-1:0] tol,
                           input logic [tkfc_pkg::FRAME_W-1:0] handle,
                           input logic [tkfc_pkg::LIMIT_W-1:0] lim);
      if (!steady && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_time_ms      <= key;
      req_tolerance    <= tol;
      req_frame_handle <= handle;
      req_new_limit    <= lim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      act_count[act]++;
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure, one long hold-off, one stretch always ready
   initial begin : receiver
      int seen;
      int hold_left;
      bit held;
      seen      = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && seen >= 100) begin
            held      = 1'b1;
            hold_left = 150;
            rsp_ready <= 1'b0;
         end else if (seen >= 300 && seen < 380) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 14);
         end
      end
   end

   initial begin : stimulus
      tkfc_pkg::action_type act;
      logic [tkfc_pkg::TIME_W-1:0]  key;
      logic [tkfc_pkg::TOL_W-1:0]   tol;
      logic [tkfc_pkg::LIMIT_W-1:0] lim;
      int unsigned base;
      int unsigned pick;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= tkfc_pkg::ACT_LOOKUP;
      req_time_ms      <= '0;
      req_tolerance    <= '0;
      req_frame_handle <= '0;
      req_new_limit    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cache, key and handle extremes, tolerance window,
      // replacement in place, limit saturation, zero limit, eviction, clear
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd0, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_STORE,  31'd0, 16'd0, 32'h0000_0000, 5'd0);
      send_req(tkfc_pkg::ACT_STORE,  31'h7FFF_FFFF, 16'd0, 32'hFFFF_FFFF, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd0, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'h7FFF_FFFF, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'h7FFF_FFFE, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'h7FFF_FFFE, 16'd1, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'h4000_0000, 16'hFFFF, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_STORE,  31'd0, 16'd0, 32'hA5A5_A5A5, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd5, 16'hFFFF, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd31);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd1);
      send_req(tkfc_pkg::ACT_STORE,  31'd100, 16'd0, 32'h1234_5678, 5'd0);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_STORE,  31'd200, 16'd0, 32'h5A5A_5A5A, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd200, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd3);
      for (int i = 1; i <= 4; i++)
         send_req(tkfc_pkg::ACT_STORE, 31'(10 * i), 16'd0, 32'(i), 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd10, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_CLEAR,  31'd0, 16'd0, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_LOOKUP, 31'd30, 16'd100, 32'd0, 5'd0);
      send_req(tkfc_pkg::ACT_STORE,  31'd7, 16'd0, 32'hDEAD_0007, 5'd0);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd15);
      send_req(tkfc_pkg::ACT_RESIZE, 31'd0, 16'd0, 32'd0, 5'd16);
      wait_drained();

      // random: keys clustered round a base so that lookups and stores hit often
      base = $urandom_range(0, 32'h7FFF_FF00);
      for (int i = 0; i < N_RANDOM; i++) begin
         steady = (i >= 300 && i < 380);
         if (i == 200)
            wait_drained();
         if ($urandom_range(0, 49) == 0)
            base = $urandom_range(0, 32'h7FFF_FF00);
         pick = $urandom_range(0, 99);
         if (pick < 45)
            act = tkfc_pkg::ACT_LOOKUP;
         else if (pick < 85)
            act = tkfc_pkg::ACT_STORE;
         else if (pick < 89)
            act = tkfc_pkg::ACT_CLEAR;
         else
            act = tkfc_pkg::ACT_RESIZE;
         if ($urandom_range(0, 9) == 0)
            key = 31'($urandom);
         else
            key = 31'(base + $urandom_range(0, 31));
         pick = $urandom_range(0, 9);
         if (pick < 4)
            tol = '0;
         else if (pick < 8)
            tol = 16'($urandom_range(1, 8));
         else
            tol = 16'($urandom);
         pick = $urandom_range(0, 9);
         if (pick < 7)
            lim = 5'($urandom_range(4, 16));
         else if (pick < 9)
            lim = 5'($urandom_range(0, 3));
         else
            lim = 5'($urandom_range(17, 31));
         send_req(act, key, tol, $urandom, lim);
      end

      wait_drained();
      repeat (CAPACITY + 10) @(posedge clock);

      $display("tb_top: %0d requests (%0d lookup, %0d store, %0d clear, %0d resize)",
               sent, act_count[tkfc_pkg::ACT_LOOKUP], act_count[tkfc_pkg::ACT_STORE],
               act_count[tkfc_pkg::ACT_CLEAR], act_count[tkfc_pkg::ACT_RESIZE]);
      $display("tb_top: %0d lookup hits, %0d mismatches, long response stall included",
               lookup_hits, mismatches);
      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
